FILE: rtl/core/wsel_pkg.sv
package wsel_pkg;

    localparam int SAMPLE_W      = 24;
    localparam int TIME_W        = 32;
    localparam int GAIN_W        = 8;
    localparam int RES_W         = 23;
    localparam int STARTUP_W     = 6;
    localparam int HOURS_W       = 16;
    localparam int SKIP_W        = 32;
    localparam int SECS_PER_HOUR = 3600;

    // shared multiplier: A x B, one 8-bit digit of B per cycle, MSB digit first
    localparam int MUL_A_W    = 64;
    localparam int MUL_B_W    = 32;
    localparam int DIGIT_W    = 8;
    localparam int MUL_DIGITS = MUL_B_W / DIGIT_W;
    localparam int DIGIT_IDX_W = $clog2(MUL_DIGITS);
    localparam int MUL_P_W    = MUL_A_W + MUL_B_W;

    // heartbeat doubling loop
    localparam int HB_INT_W  = HOURS_W + 1;
    localparam int HB_ACC_W  = 34;
    localparam int HB_NEED_W = 28;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    typedef enum logic [3:0] {
        OP_G2,
        OP_NP,
        OP_S1SQ,
        OP_NS2,
        OP_DEV2,
        OP_L,
        OP_R,
        OP_O2,
        OP_X2
    } t_mul_op;

    typedef enum logic [2:0] {
        REG_DELTA_GAIN  = 3'd0,
        REG_RESOLUTION  = 3'd1,
        REG_STARTUP     = 3'd2,
        REG_BASE_HOURS  = 3'd3,
        REG_MAX_HOURS   = 3'd4,
        REG_DOUBLING    = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [GAIN_W-1:0]    delta_gain;
        logic [RES_W-1:0]     resolution;
        logic [STARTUP_W-1:0] startup_samples;
        logic [HOURS_W-1:0]   base_hours;
        logic [HOURS_W-1:0]   max_hours;
        logic [HOURS_W-1:0]   doubling_period_hours;
    } t_cfg;

    typedef struct packed {
        logic                   capture;
        logic                   mul_en;
        t_mul_op                mul_op;
        logic [DIGIT_IDX_W-1:0] mul_digit;
        logic                   hb_start;
        logic                   hb_step;
        logic                   commit;
    } t_ctl_cmd;

    typedef struct packed {
        logic hb_done;
        logic out_free;
    } t_ctl_sts;

endpackage

FILE: rtl/core/wsel_if.sv
interface wsel_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [wsel_pkg::SAMPLE_W-1:0] sample;
    logic [wsel_pkg::TIME_W-1:0]          now_seconds;

    modport source (output valid, sample, now_seconds, input ready);
    modport sink   (input valid, sample, now_seconds, output ready);
endinterface

interface wsel_out_if;
    logic                        valid;
    logic                        ready;
    logic                        transmit;
    logic                        event_hit;
    logic                        heartbeat_hit;
    logic [wsel_pkg::SKIP_W-1:0] skipped_run;

    modport source (output valid, transmit, event_hit, heartbeat_hit, skipped_run,
                    input ready);
    modport sink   (input valid, transmit, event_hit, heartbeat_hit, skipped_run,
                    output ready);
endinterface

FILE: rtl/core/windowed_stddev_event_logger.sv
// Channel      Dir   Words
// -----------  ----  ------------------------------------------------------
// i_sample_ch  in    sample (s24), now_seconds (u32)
// o_result_ch  out   transmit, event_hit, heartbeat_hit, skipped_run (u32)
// APB          in    6 config registers at 4*i, write on psel&penable&pwrite
//
// One word at a time: accept, the shared 64x8 digit multiplier (nine products,
// four digits each), heartbeat doubling, then commit.
// Reset (i_rst_n, synchronous) empties the window; an unwritten slot's value is never used.
// A result waits in the output register; a stalled sink holds the commit
// of the next word until that register frees up.
module windowed_stddev_event_logger #(
    parameter int WINDOW = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    wsel_in_if.sink                             i_sample_ch,
    wsel_out_if.source                          o_result_ch,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [wsel_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [wsel_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [wsel_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    wsel_pkg::t_cfg     r_cfg;
    wsel_pkg::t_ctl_cmd cmd;
    wsel_pkg::t_ctl_sts sts;
    logic [2:0]         reg_idx;

    assign reg_idx = paddr[4:2];
    assign pready  = 1'b1;

    // config registers, written in the APB access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.delta_gain            <= 8'd32;
            r_cfg.resolution            <= 23'd1;
            r_cfg.startup_samples       <= 6'd8;
            r_cfg.base_hours            <= 16'd1;
            r_cfg.max_hours             <= 16'd24;
            r_cfg.doubling_period_hours <= 16'd6;
        end else if (psel && penable && pwrite) begin
            unique case (reg_idx)
                wsel_pkg::REG_DELTA_GAIN: r_cfg.delta_gain <= pwdata[7:0];
                wsel_pkg::REG_RESOLUTION: r_cfg.resolution <= pwdata[22:0];
                wsel_pkg::REG_STARTUP:    r_cfg.startup_samples <= pwdata[5:0];
                wsel_pkg::REG_BASE_HOURS: r_cfg.base_hours <= pwdata[15:0];
                wsel_pkg::REG_MAX_HOURS:  r_cfg.max_hours <= pwdata[15:0];
                wsel_pkg::REG_DOUBLING:   r_cfg.doubling_period_hours <= pwdata[15:0];
                default: ;  // beyond the register list: ignored
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            wsel_pkg::REG_DELTA_GAIN: prdata = 32'(r_cfg.delta_gain);
            wsel_pkg::REG_RESOLUTION: prdata = 32'(r_cfg.resolution);
            wsel_pkg::REG_STARTUP:    prdata = 32'(r_cfg.startup_samples);
            wsel_pkg::REG_BASE_HOURS: prdata = 32'(r_cfg.base_hours);
            wsel_pkg::REG_MAX_HOURS:  prdata = 32'(r_cfg.max_hours);
            wsel_pkg::REG_DOUBLING:   prdata = 32'(r_cfg.doubling_period_hours);
            default:                  prdata = '0;
        endcase
    end

    wsel_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_sample_ch.valid),
        .o_in_ready (i_sample_ch.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    wsel_dp #(
        .WINDOW (WINDOW)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_cfg           (r_cfg),
        .i_sample        (i_sample_ch.sample),
        .i_now           (i_sample_ch.now_seconds),
        .o_out_valid     (o_result_ch.valid),
        .i_out_ready     (o_result_ch.ready),
        .o_transmit      (o_result_ch.transmit),
        .o_event_hit     (o_result_ch.event_hit),
        .o_heartbeat_hit (o_result_ch.heartbeat_hit),
        .o_skipped_run   (o_result_ch.skipped_run)
    );

`ifndef SYNTHESIS
    // a word is sent exactly when an event or a heartbeat fired
    a_tx_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_ch.valid |-> (o_result_ch.transmit ==
                               (o_result_ch.event_hit || o_result_ch.heartbeat_hit)))
        else $error("transmit does not match event/heartbeat");

    // skip run restarts on a send and counts otherwise
    a_skip_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_ch.valid |-> (o_result_ch.transmit == (o_result_ch.skipped_run == '0)))
        else $error("skipped_run inconsistent with transmit");

    // one word in flight: no accept in the cycle after an accept
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_sample_ch.valid && i_sample_ch.ready) |=> !i_sample_ch.ready)
        else $error("input accepted while busy");
`endif

endmodule

FILE: rtl/core/wsel_ctrl.sv
module wsel_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  wsel_pkg::t_ctl_sts i_sts,
    output wsel_pkg::t_ctl_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_HB_INIT,
        S_HB_RUN,
        S_DONE
    } t_state;

    localparam logic [wsel_pkg::DIGIT_IDX_W-1:0] LAST_DIGIT =
        wsel_pkg::DIGIT_IDX_W'(wsel_pkg::MUL_DIGITS - 1);

    t_state                                r_state;
    wsel_pkg::t_mul_op                     r_op;
    logic [wsel_pkg::DIGIT_IDX_W-1:0]      r_dig;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= wsel_pkg::OP_G2;
            r_dig   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_MUL;
                        r_op    <= wsel_pkg::OP_G2;
                        r_dig   <= '0;
                    end
                end
                S_MUL: begin
                    r_dig <= r_dig + 1'b1;
                    if (r_dig == LAST_DIGIT) begin
                        if (r_op == wsel_pkg::OP_X2) begin
                            r_state <= S_HB_INIT;
                        end else begin
                            r_op <= wsel_pkg::t_mul_op'(r_op + 1'b1);
                        end
                    end
                end
                S_HB_INIT: begin
                    r_state <= S_HB_RUN;
                end
                S_HB_RUN: begin
                    if (i_sts.hb_done) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (i_sts.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd.capture   = (r_state == S_IDLE) && i_in_valid;
        o_cmd.mul_en    = (r_state == S_MUL);
        o_cmd.mul_op    = r_op;
        o_cmd.mul_digit = r_dig;
        o_cmd.hb_start  = (r_state == S_HB_INIT);
        o_cmd.hb_step   = (r_state == S_HB_RUN);
        o_cmd.commit    = (r_state == S_DONE) && i_sts.out_free;
    end

endmodule

FILE: rtl/core/wsel_dp.sv
module wsel_dp #(
    parameter int WINDOW = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  wsel_pkg::t_ctl_cmd                    i_cmd,
    output wsel_pkg::t_ctl_sts                    o_sts,
    input  wsel_pkg::t_cfg                        i_cfg,
    input  logic signed [wsel_pkg::SAMPLE_W-1:0]  i_sample,
    input  logic [wsel_pkg::TIME_W-1:0]           i_now,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic                                  o_transmit,
    output logic                                  o_event_hit,
    output logic                                  o_heartbeat_hit,
    output logic [wsel_pkg::SKIP_W-1:0]           o_skipped_run
);

    localparam int SW     = wsel_pkg::SAMPLE_W;
    localparam int SLOT_W = $clog2(WINDOW);
    localparam int FILL_W = $clog2(WINDOW + 1);
    localparam int S1_W   = SW + 1 + SLOT_W;
    localparam int S2_W   = 2 * SW + SLOT_W;
    localparam int CMP_W  = (FILL_W > wsel_pkg::STARTUP_W) ? FILL_W : wsel_pkg::STARTUP_W;
    localparam int SQ_W   = 2 * SW;
    localparam int PART_W = wsel_pkg::MUL_A_W + wsel_pkg::DIGIT_W;
    localparam logic [wsel_pkg::DIGIT_IDX_W-1:0] LAST_DIGIT =
        wsel_pkg::DIGIT_IDX_W'(wsel_pkg::MUL_DIGITS - 1);

    // item registers
    logic signed [SW-1:0]              r_x;
    logic [wsel_pkg::TIME_W-1:0]       r_now;
    logic [SW-1:0]                     r_dev;

    // window
    logic signed [SW-1:0]              r_mem [WINDOW];
    logic signed [SW-1:0]              r_old;
    logic [SLOT_W-1:0]                 r_slot;
    logic [FILL_W-1:0]                 r_fill;
    logic signed [S1_W-1:0]            r_s1;
    logic [S2_W-1:0]                   r_s2;

    // send history
    logic                              r_has_sent;
    logic signed [SW-1:0]              r_last_val;
    logic [wsel_pkg::TIME_W-1:0]       r_last_send;
    logic [wsel_pkg::TIME_W-1:0]       r_last_event;
    logic [wsel_pkg::SKIP_W-1:0]       r_skip;

    // products
    logic [wsel_pkg::MUL_P_W-1:0]      r_acc;
    logic [2*wsel_pkg::GAIN_W-1:0]     r_g2;
    logic [15:0]                       r_np;
    logic [wsel_pkg::MUL_A_W-1:0]      r_s1sq;
    logic [wsel_pkg::MUL_A_W-1:0]      r_d;
    logic [SQ_W-1:0]                   r_dv2;
    logic [wsel_pkg::MUL_P_W-1:0]      r_l;
    logic [wsel_pkg::MUL_P_W-1:0]      r_r;
    logic [SQ_W-1:0]                   r_o2;
    logic [SQ_W-1:0]                   r_x2;

    // heartbeat loop
    logic [wsel_pkg::HB_ACC_W-1:0]     r_hb_acc;
    logic [wsel_pkg::HB_INT_W-1:0]     r_hb_int;
    logic                              r_hb_done;

    // output word
    logic                              r_out_valid;
    logic                              r_out_tx;
    logic                              r_out_ev;
    logic                              r_out_hb;
    logic [wsel_pkg::SKIP_W-1:0]       r_out_skip;

    logic signed [SW:0]                n_diff;
    logic [SW:0]                       n_diff_mag;
    logic [S1_W-1:0]                   n_s1_mag;
    logic [SW-1:0]                     n_old_mag;
    logic [SW-1:0]                     n_x_mag;
    logic [wsel_pkg::MUL_A_W-1:0]      n_mul_a;
    logic [wsel_pkg::MUL_B_W-1:0]      n_mul_b;
    logic [wsel_pkg::DIGIT_W-1:0]      n_digit;
    logic [PART_W-1:0]                 n_part;
    logic [wsel_pkg::MUL_P_W-1:0]      n_acc;
    logic                              n_mul_last;

    logic [wsel_pkg::HB_ACC_W-1:0]     n_hb_period;
    logic [wsel_pkg::HB_ACC_W-1:0]     n_calm;
    logic [wsel_pkg::HOURS_W-1:0]      n_hours;
    logic [wsel_pkg::HB_NEED_W-1:0]    n_need;
    logic [wsel_pkg::TIME_W-1:0]       n_elapsed;
    logic                              n_use_sd;
    logic                              n_ev;
    logic                              n_hb;
    logic                              n_tx;

    // magnitudes
    always_comb begin
        n_diff     = (SW + 1)'(i_sample) - (SW + 1)'(r_last_val);
        n_diff_mag = n_diff[SW] ? (SW + 1)'(-n_diff) : n_diff;
        n_s1_mag   = r_s1[S1_W-1] ? S1_W'(-r_s1) : S1_W'(r_s1);
        n_old_mag  = r_old[SW-1] ? SW'(-r_old) : SW'(r_old);
        n_x_mag    = r_x[SW-1] ? SW'(-r_x) : SW'(r_x);
    end

    // operand selection for the shared digit multiplier
    always_comb begin
        unique case (i_cmd.mul_op)
            wsel_pkg::OP_G2: begin
                n_mul_a = wsel_pkg::MUL_A_W'(i_cfg.delta_gain);
                n_mul_b = wsel_pkg::MUL_B_W'(i_cfg.delta_gain);
            end
            wsel_pkg::OP_NP: begin
                n_mul_a = wsel_pkg::MUL_A_W'(r_fill);
                n_mul_b = wsel_pkg::MUL_B_W'(FILL_W'(r_fill - 1'b1));
            end
            wsel_pkg::OP_S1SQ: begin
                n_mul_a = wsel_pkg::MUL_A_W'(n_s1_mag);
                n_mul_b = wsel_pkg::MUL_B_W'(n_s1_mag);
            end
            wsel_pkg::OP_NS2: begin
                n_mul_a = wsel_pkg::MUL_A_W'(r_s2);
                n_mul_b = wsel_pkg::MUL_B_W'(r_fill);
            end
            wsel_pkg::OP_DEV2: begin
                n_mul_a = wsel_pkg::MUL_A_W'(r_dev);
                n_mul_b = wsel_pkg::MUL_B_W'(r_dev);
            end
            wsel_pkg::OP_L: begin
                n_mul_a = wsel_pkg::MUL_A_W'({r_dv2, 8'd0});
                n_mul_b = wsel_pkg::MUL_B_W'(r_np);
            end
            wsel_pkg::OP_R: begin
                n_mul_a = r_d;
                n_mul_b = wsel_pkg::MUL_B_W'(r_g2);
            end
            wsel_pkg::OP_O2: begin
                n_mul_a = wsel_pkg::MUL_A_W'(n_old_mag);
                n_mul_b = wsel_pkg::MUL_B_W'(n_old_mag);
            end
            wsel_pkg::OP_X2: begin
                n_mul_a = wsel_pkg::MUL_A_W'(n_x_mag);
                n_mul_b = wsel_pkg::MUL_B_W'(n_x_mag);
            end
            default: begin
                n_mul_a = '0;
                n_mul_b = '0;
            end
        endcase
    end

    always_comb begin
        n_digit = wsel_pkg::DIGIT_W'(n_mul_b >> (wsel_pkg::DIGIT_W *
                  (wsel_pkg::MUL_DIGITS - 1 - int'(i_cmd.mul_digit))));
        n_part  = PART_W'(n_mul_a) * PART_W'(n_digit);
        if (i_cmd.mul_digit == '0) begin
            n_acc = wsel_pkg::MUL_P_W'(n_part);
        end else begin
            n_acc = (r_acc << wsel_pkg::DIGIT_W) + wsel_pkg::MUL_P_W'(n_part);
        end
        n_mul_last = i_cmd.mul_en && (i_cmd.mul_digit == LAST_DIGIT);
    end

    // heartbeat interval and decision
    always_comb begin
        n_hb_period = wsel_pkg::HB_ACC_W'(i_cfg.doubling_period_hours) *
                      wsel_pkg::HB_ACC_W'(wsel_pkg::SECS_PER_HOUR);
        n_calm      = wsel_pkg::HB_ACC_W'(r_now - r_last_event);
        if (i_cfg.doubling_period_hours == '0) begin
            n_hours = i_cfg.max_hours;
        end else if (r_hb_int < wsel_pkg::HB_INT_W'(i_cfg.max_hours)) begin
            n_hours = wsel_pkg::HOURS_W'(r_hb_int);
        end else begin
            n_hours = i_cfg.max_hours;
        end
        n_need    = wsel_pkg::HB_NEED_W'(n_hours) *
                    wsel_pkg::HB_NEED_W'(wsel_pkg::SECS_PER_HOUR);
        n_elapsed = r_now - r_last_send;
        n_hb      = !r_has_sent ||
                    (n_elapsed >= wsel_pkg::TIME_W'(n_need));
        n_use_sd  = (CMP_W'(r_fill) >= CMP_W'(i_cfg.startup_samples)) &&
                    (r_fill >= FILL_W'(2));
        n_ev      = r_has_sent && (r_dev > SW'(i_cfg.resolution)) &&
                    (!n_use_sd || (r_l > r_r));
        n_tx      = n_ev || n_hb;
    end

    // window store: registered read at the current slot
    always_ff @(posedge i_clk) begin
        r_old <= r_mem[r_slot];
        if (i_cmd.commit) begin
            r_mem[r_slot] <= r_x;
        end
    end

    // payload and product registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_x   <= i_sample;
            r_now <= i_now;
            r_dev <= SW'(n_diff_mag);
        end
        if (i_cmd.mul_en) begin
            r_acc <= n_acc;
        end
        if (n_mul_last) begin
            unique case (i_cmd.mul_op)
                wsel_pkg::OP_G2:   r_g2   <= (2*wsel_pkg::GAIN_W)'(n_acc);
                wsel_pkg::OP_NP:   r_np   <= 16'(n_acc);
                wsel_pkg::OP_S1SQ: r_s1sq <= wsel_pkg::MUL_A_W'(n_acc);
                wsel_pkg::OP_NS2:  r_d    <= wsel_pkg::MUL_A_W'(n_acc) - r_s1sq;
                wsel_pkg::OP_DEV2: r_dv2  <= SQ_W'(n_acc);
                wsel_pkg::OP_L:    r_l    <= n_acc;
                wsel_pkg::OP_R:    r_r    <= n_acc;
                wsel_pkg::OP_O2:   r_o2   <= SQ_W'(n_acc);
                wsel_pkg::OP_X2:   r_x2   <= SQ_W'(n_acc);
                default: ;
            endcase
        end
        if (i_cmd.hb_start) begin
            r_hb_acc <= n_hb_period;
            r_hb_int <= wsel_pkg::HB_INT_W'(i_cfg.base_hours);
        end else if (i_cmd.hb_step && !r_hb_done) begin
            if ((r_hb_int < wsel_pkg::HB_INT_W'(i_cfg.max_hours)) && (r_hb_int != '0) &&
                (n_calm >= r_hb_acc)) begin
                r_hb_int <= r_hb_int << 1;
                r_hb_acc <= r_hb_acc + n_hb_period;
            end
        end
        if (i_cmd.commit) begin
            r_out_tx   <= n_tx;
            r_out_ev   <= n_ev;
            r_out_hb   <= n_hb;
            r_out_skip <= n_tx ? '0 : r_skip + 1'b1;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hb_done    <= 1'b0;
            r_slot       <= '0;
            r_fill       <= '0;
            r_s1         <= '0;
            r_s2         <= '0;
            r_has_sent   <= 1'b0;
            r_last_val   <= '0;
            r_last_send  <= '0;
            r_last_event <= '0;
            r_skip       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.hb_start) begin
                r_hb_done <= (i_cfg.doubling_period_hours == '0);
            end else if (i_cmd.hb_step && !r_hb_done) begin
                if (!((r_hb_int < wsel_pkg::HB_INT_W'(i_cfg.max_hours)) && (r_hb_int != '0) &&
                      (n_calm >= r_hb_acc))) begin
                    r_hb_done <= 1'b1;
                end
            end

            if (i_cmd.commit) begin
                if (r_fill == FILL_W'(WINDOW)) begin
                    r_s1 <= r_s1 - S1_W'(r_old) + S1_W'(r_x);
                    r_s2 <= r_s2 - S2_W'(r_o2) + S2_W'(r_x2);
                end else begin
                    r_fill <= r_fill + 1'b1;
                    r_s1   <= r_s1 + S1_W'(r_x);
                    r_s2   <= r_s2 + S2_W'(r_x2);
                end
                r_slot <= (r_slot == SLOT_W'(WINDOW - 1)) ? '0 : r_slot + 1'b1;
                if (n_tx) begin
                    r_last_send <= r_now;
                    if (n_ev || !r_has_sent) begin
                        r_last_event <= r_now;
                    end
                    r_has_sent <= 1'b1;
                    r_last_val <= r_x;
                    r_skip     <= '0;
                end else begin
                    r_skip <= r_skip + 1'b1;
                end
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.hb_done  = r_hb_done;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid     = r_out_valid;
    assign o_transmit      = r_out_tx;
    assign o_event_hit     = r_out_ev;
    assign o_heartbeat_hit = r_out_hb;
    assign o_skipped_run   = r_out_skip;

endmodule
